// ----- hdl/necir_pkg.sv -----
package necir_pkg;

	// Frame length in bits and the width of the emitted code.
	localparam int CODE_BITS = 32;
	localparam int CMD_W     = 32;
	localparam int TICK_W    = 16;
	localparam int CNT_W     = $clog2(CODE_BITS + 1);
	localparam int EXT_W     = (CODE_BITS > CMD_W) ? CODE_BITS : CMD_W;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd2;

	localparam logic [TICK_W-1:0] RST_LEADER_MIN    = 16'd1840;
	localparam logic [TICK_W-1:0] RST_LEADER_MAX    = 16'd2640;
	localparam logic [TICK_W-1:0] RST_ONE_THRESHOLD = 16'd330;

	typedef struct packed {
		logic [TICK_W-1:0] leader_min;
		logic [TICK_W-1:0] leader_max;
		logic [TICK_W-1:0] one_threshold;
	} cfg_t;

	typedef struct packed {
		logic              func;
		logic [TICK_W-1:0] ticks;
		logic              rising;
	} event_t;

	typedef struct packed {
		logic             valid;
		logic [CMD_W-1:0] code;
		logic             is_repeat;
	} result_t;

endpackage

// ----- hdl/necir_cfg.sv -----
module necir_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [necir_pkg::CFG_IDX_W-1:0]     index,
	input  logic [necir_pkg::CFG_DAT_W-1:0]     data,
	output necir_pkg::cfg_t                     cfg
);

	necir_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min    <= necir_pkg::RST_LEADER_MIN;
			cfg_q.leader_max    <= necir_pkg::RST_LEADER_MAX;
			cfg_q.one_threshold <= necir_pkg::RST_ONE_THRESHOLD;
		end else if (wr_en) begin
			unique case (index)
				necir_pkg::REG_LEADER_MIN:    cfg_q.leader_min    <= data;
				necir_pkg::REG_LEADER_MAX:    cfg_q.leader_max    <= data;
				necir_pkg::REG_ONE_THRESHOLD: cfg_q.one_threshold <= data;
				default: ; // unused indexes are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/necir_core.sv -----
module necir_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  necir_pkg::event_t    ev,
	input  necir_pkg::cfg_t      cfg,
	output necir_pkg::result_t   res
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_LEADER = 2'd1,
		PH_FIRST  = 2'd2,
		PH_RECV   = 2'd3
	} phase_t;

	phase_t                           phase_q, phase_d;
	logic [necir_pkg::CNT_W-1:0]      bit_count_q, bit_count_d, cnt_inc;
	logic [necir_pkg::CODE_BITS-1:0]  code_q, code_d;
	logic [necir_pkg::EXT_W-1:0]      code_ext;
	logic                             bit_val;

	assign cnt_inc  = bit_count_q + necir_pkg::CNT_W'(1);
	assign bit_val  = ev.ticks > cfg.one_threshold;
	assign code_ext = necir_pkg::EXT_W'({code_q[necir_pkg::CODE_BITS-2:0], bit_val});

	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		code_d        = code_q;
		res.valid     = 1'b0;
		res.code      = '0;
		res.is_repeat = 1'b0;
		if (ev.func) begin
			// A timeout always ends the frame; in the receive phase before any bit it is a repeat.
			phase_d = PH_IDLE;
			if (phase_q == PH_RECV && bit_count_q == '0) begin
				res.valid     = 1'b1;
				res.is_repeat = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (!ev.rising) begin
						phase_d     = PH_LEADER;
						bit_count_d = '0;
						code_d      = '0;
					end
				end
				PH_LEADER: begin
					if (ev.ticks > cfg.leader_min && ev.ticks < cfg.leader_max) begin
						phase_d = PH_FIRST;
					end
				end
				PH_FIRST: begin
					phase_d = PH_RECV;
				end
				PH_RECV: begin
					if (!ev.rising) begin
						code_d      = code_ext[necir_pkg::CODE_BITS-1:0];
						bit_count_d = cnt_inc;
						if (cnt_inc == necir_pkg::CNT_W'(necir_pkg::CODE_BITS)) begin
							phase_d   = PH_IDLE;
							res.valid = 1'b1;
							res.code  = code_ext[necir_pkg::CMD_W-1:0];
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			code_q      <= '0;
		end else if (en) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			code_q      <= code_d;
		end
	end

	// A timeout always leaves the decoder idle.
	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev.func |=> phase_q == PH_IDLE)
		else $error("timeout did not return decoder to idle");

	// The bit counter never runs past a whole frame.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= necir_pkg::CNT_W'(necir_pkg::CODE_BITS))
		else $error("bit counter beyond frame length");

	// A new code is only emitted at the end of a frame, which leaves the decoder idle.
	a_code_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.valid && !res.is_repeat |=>
			phase_q == PH_IDLE && bit_count_q == necir_pkg::CNT_W'(necir_pkg::CODE_BITS))
		else $error("code emitted without a full frame");

	// A repeat carries no code bits.
	a_repeat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_repeat |-> res.code == '0)
		else $error("repeat result with non-zero code");

	// Entering the leader phase from idle starts with an empty counter.
	a_leader_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && !ev.func && !ev.rising && phase_q == PH_IDLE |=>
			phase_q == PH_LEADER && bit_count_q == '0)
		else $error("frame start did not clear the bit counter");

endmodule

// ----- hdl/nec_ir_frame_decoder_top.sv -----
// Channel   Direction  Handshake               Payload
// ------    ---------  ---------------------   ---------------------------------------
// in        input      in_valid / in_ready      func, capture_ticks, rising_edge
// out       output     out_valid / out_ready    command_code, is_repeat
// cfg       input      cfg_wr_en (no wait)      cfg_index, cfg_data
//
// Each input word is captured in a register, decoded by the frame state
// machine and its result, if any, lands in the output register: the word
// goes through the input register and then the output register, and one
// word per cycle is sustained while out_ready keeps the output draining.
// The rate is set by the frame state update feeding the output
// register. Reset (arst_n low) empties both registers, returns the decoder to
// idle and loads the default leader window and bit threshold. When the output
// register holds a word that is not taken, the input register keeps its word
// and in_ready drops once the input register is full as well.
module nec_ir_frame_decoder_top (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [necir_pkg::TICK_W-1:0]        capture_ticks,
	input  logic                                rising_edge,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [necir_pkg::CMD_W-1:0]         command_code,
	output logic                                is_repeat,

	input  logic                                cfg_wr_en,
	input  logic [necir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [necir_pkg::CFG_DAT_W-1:0]     cfg_data
);

	necir_pkg::cfg_t    cfg;
	necir_pkg::event_t  ev_s1;
	necir_pkg::result_t res;

	logic                         valid_s1;
	logic                         out_valid_s2;
	logic [necir_pkg::CMD_W-1:0]  code_s2;
	logic                         repeat_s2;
	logic                         out_free;
	logic                         fire_s1;
	logic                         in_take;

	// The output register can take a new word when it is empty or being drained.
	assign out_free = !out_valid_s2 || out_ready;
	assign fire_s1  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_take  = in_valid && in_ready;

	necir_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Input register: the word waiting for the decoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ev_s1.func   <= func;
			ev_s1.ticks  <= capture_ticks;
			ev_s1.rising <= rising_edge;
		end
	end

	necir_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire_s1),
		.ev     (ev_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Output register: only words that produce a result fill it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			out_valid_s2 <= res.valid;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res.valid) begin
			code_s2   <= res.code;
			repeat_s2 <= res.is_repeat;
		end
	end

	assign out_valid    = out_valid_s2;
	assign command_code = code_s2;
	assign is_repeat    = repeat_s2;

endmodule
